// ===== hdl/u2u_pkg.sv =====
// Shared types and constants for the UTF-8 to UCS-2 stream decoder.
// No dependencies; used by u2u_core and utf8_to_ucs2_stream_decoder.
`default_nettype none

package u2u_pkg;

    // Result kind, carried on m_axis_tuser
    typedef enum logic [1:0] {
        KIND_CHAR = 2'd0,
        KIND_END  = 2'd1,
        KIND_BAD  = 2'd2,
        KIND_FULL = 2'd3
    } kind_t;

    localparam int unsigned UNIT_W  = 16;
    localparam int unsigned BYTE_W  = 8;

    // Limit after reset
    localparam logic [UNIT_W-1:0] MAX_UNITS_RST = 16'hffff;

    // Lead byte tags
    localparam logic [2:0] LEAD2_TAG = 3'b110;
    localparam logic [3:0] LEAD3_TAG = 4'b1110;

    // One decoded result from the core
    typedef struct packed {
        logic              has_result;
        logic [UNIT_W-1:0] code_unit;
        kind_t             kind;
        logic [UNIT_W-1:0] unit_count;
    } result_t;

endpackage

`default_nettype wire

// ===== hdl/u2u_core.sv =====
// Decoder state and per-byte decode logic of the UTF-8 to UCS-2 decoder.
// Depends on u2u_pkg for the result struct and kind codes.
`default_nettype none

module u2u_core (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       fire,        // byte consumed this cycle
    input  wire logic [u2u_pkg::BYTE_W-1:0] in_byte,
    input  wire logic [u2u_pkg::UNIT_W-1:0] max_units,
    output u2u_pkg::result_t                result
);

    logic [1:0]                  pending_reg,  pending_next;
    logic [u2u_pkg::UNIT_W-1:0]  partial_reg,  partial_next;
    logic [u2u_pkg::UNIT_W-1:0]  units_reg,    units_next;
    logic                        halted_reg,   halted_next;

    // Update decoder state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= 2'd0;
            partial_reg <= '0;
            units_reg   <= '0;
            halted_reg  <= 1'b0;
        end
        else
        begin
            pending_reg <= pending_next;
            partial_reg <= partial_next;
            units_reg   <= units_next;
            halted_reg  <= halted_next;
        end
    end

    // Decode one byte
    always_comb
    begin
        pending_next      = pending_reg;
        partial_next      = partial_reg;
        units_next        = units_reg;
        halted_next       = halted_reg;
        result.has_result = 1'b0;
        result.code_unit  = '0;
        result.kind       = u2u_pkg::KIND_CHAR;
        result.unit_count = units_reg;

        if (fire)
        begin
            priority if (halted_reg)
            begin
                // Drop bytes until a terminator re-arms
                if (in_byte == '0)
                begin
                    halted_next  = 1'b0;
                    pending_next = 2'd0;
                    partial_next = '0;
                    units_next   = '0;
                end
            end
            else if (in_byte == '0)
            begin
                // End of string, any partial character is dropped
                result.has_result = 1'b1;
                result.kind       = u2u_pkg::KIND_END;
                pending_next      = 2'd0;
                partial_next      = '0;
                units_next        = '0;
            end
            else if (pending_reg == 2'd0)
            begin
                priority if (units_reg >= max_units)
                begin
                    halted_next       = 1'b1;
                    result.has_result = 1'b1;
                    result.kind       = u2u_pkg::KIND_FULL;
                end
                else if (!in_byte[7])
                begin
                    units_next        = units_reg + 16'd1;
                    result.has_result = 1'b1;
                    result.code_unit  = {8'h00, in_byte};
                    result.unit_count = units_reg + 16'd1;
                end
                else if (in_byte[7:5] == u2u_pkg::LEAD2_TAG)
                begin
                    partial_next = {5'b0, in_byte[4:0], 6'b0};
                    pending_next = 2'd1;
                end
                else if (in_byte[7:4] == u2u_pkg::LEAD3_TAG)
                begin
                    partial_next = {in_byte[3:0], 12'b0};
                    pending_next = 2'd2;
                end
                else
                begin
                    halted_next       = 1'b1;
                    result.has_result = 1'b1;
                    result.kind       = u2u_pkg::KIND_BAD;
                end
            end
            else if (pending_reg == 2'd2)
            begin
                // Middle continuation byte
                partial_next = partial_reg | {4'b0, in_byte[5:0], 6'b0};
                pending_next = 2'd1;
            end
            else
            begin
                // Last continuation byte completes the unit
                partial_next      = '0;
                pending_next      = 2'd0;
                units_next        = units_reg + 16'd1;
                result.has_result = 1'b1;
                result.code_unit  = partial_reg | {10'b0, in_byte[5:0]};
                result.unit_count = units_reg + 16'd1;
            end
        end
    end

    // Terminator always leaves a clean, empty string state
    a_term_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && in_byte == '0) |=> (units_reg == '0 && pending_reg == 2'd0
                                     && !halted_reg))
        else $error("terminator did not clear decoder state");

    // Three pending bytes is never reached
    a_pending_range: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg != 2'd3)
        else $error("pending count reached three");

    // A halted decoder stays silent
    a_halted_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        halted_reg |-> !result.has_result)
        else $error("result produced while halted");

endmodule

`default_nettype wire

// ===== hdl/utf8_to_ucs2_stream_decoder.sv =====
// Top level of the UTF-8 to UCS-2 stream decoder: stream ports, limit register,
// input and result registers. Depends on u2u_pkg and u2u_core.
`default_nettype none

// One UTF-8 byte is taken per transfer on s_axis, and the decoder sustains one
// byte per clock while m_axis_tready does not hold off the result register. A
// byte passes an input register, is decoded by u2u_core, and its result (if any)
// sits in the result register, which drives m_axis_tvalid. Lead and middle
// bytes of multi-byte characters give no result; a finished character, a
// terminator that does not re-arm a halted decoder, a bad lead byte or a
// capacity stop each give one. s_axis_tready follows m_axis_tready within the
// cycle when both registers are full. Write max_units only while no string is
// in flight; it takes effect at the next lead byte.

module utf8_to_ucs2_stream_decoder (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Limit register write
    input  wire logic        cfg_wr_en,
    input  wire logic [15:0] cfg_wr_data,    // max_units
    // Byte input
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    // Result output
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // [15:0] code_unit, [31:16] unit_count
    output logic [1:0]       m_axis_tuser    // [1:0] kind
);

    logic [u2u_pkg::UNIT_W-1:0] max_units_reg;
    logic                       in_valid_reg;
    logic [u2u_pkg::BYTE_W-1:0] in_byte_reg;
    logic                       out_valid_reg, out_valid_next;
    logic [31:0]                out_data_reg;
    logic [1:0]                 out_user_reg;
    logic                       advance;
    logic                       s_fire;
    u2u_pkg::result_t           result;

    // Hold the limit register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_units_reg <= u2u_pkg::MAX_UNITS_RST;
        else if (cfg_wr_en)
            max_units_reg <= cfg_wr_data;
    end

    // Advance the input byte when the result register can take its result
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign s_fire        = s_axis_tvalid && s_axis_tready;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tready)
            in_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
            in_byte_reg <= s_axis_tdata;
    end

    u2u_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (advance),
        .in_byte   (in_byte_reg),
        .max_units (max_units_reg),
        .result    (result)
    );

    // Result register valid: load on advance, drop on output transfer
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = result.has_result;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (advance && result.has_result)
        begin
            out_data_reg <= {result.unit_count, result.code_unit};
            out_user_reg <= result.kind;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;

    // Non-character results carry a zero code unit
    a_noncode_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser != u2u_pkg::KIND_CHAR) |-> (m_axis_tdata[15:0] == '0))
        else $error("non-character result with nonzero code unit");

    // A character result always counts at least itself
    a_char_count: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser == u2u_pkg::KIND_CHAR) |-> (m_axis_tdata[31:16] != '0))
        else $error("character result with zero unit count");

    // A byte is decoded only into a free or draining result register
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && out_valid_reg) |-> m_axis_tready)
        else $error("result register overwritten while stalled");

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
// Self-checking testbench for utf8_to_ucs2_stream_decoder: byte stream in, code units out.
// Depends on u2u_pkg and the decoder RTL; predicts every result with a local decoder model.
`timescale 1ns / 100ps

module tb;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 8;

    typedef struct {
        logic [15:0]      code_unit;
        u2u_pkg::kind_t   kind;
        logic [15:0]      unit_count;
    } unit_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [15:0] cfg_wr_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;

    // Decoder model state
    logic [1:0]  dec_pending = '0;
    logic [15:0] dec_partial = '0;
    logic [15:0] dec_units = '0;
    logic        dec_halted = 1'b0;
    logic [15:0] dec_limit = u2u_pkg::MAX_UNITS_RST;

    unit_result_t expected_units[$];
    int error_count   = 0;
    int decoded_items = 0;
    int cycle_count   = 0;

    // Idle and hold-off controls
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_len      = 0;
    int hold_request  = 0;
    int hold_served   = 0;
    int hold_left     = 0;

    utf8_to_ucs2_stream_decoder dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Stop a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic report_failure(input string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        error_count++;
    endtask

    task automatic queue_unit(input logic [15:0] unit, input u2u_pkg::kind_t kind,
                              input logic [15:0] count);
        unit_result_t r;
        r.code_unit  = unit;
        r.kind       = kind;
        r.unit_count = count;
        expected_units.push_back(r);
    endtask

    task automatic clear_string();
        dec_pending = '0;
        dec_partial = '0;
        dec_units   = '0;
    endtask

    // Advance the decoder model by one accepted byte
    task automatic decode_byte(input logic [7:0] b);
        decoded_items++;
        if (dec_halted)
        begin
            // Drop everything until a zero byte re-arms
            if (b == 8'h00)
            begin
                dec_halted = 1'b0;
                clear_string();
            end
        end
        else
        begin
            if (b == 8'h00)
            begin
                queue_unit(16'h0000, u2u_pkg::KIND_END, dec_units);
                clear_string();
            end
            else if (dec_pending == 2'd0)
            begin
                if (dec_units >= dec_limit)
                begin
                    dec_halted = 1'b1;
                    queue_unit(16'h0000, u2u_pkg::KIND_FULL, dec_units);
                end
                else if (!b[7])
                begin
                    dec_units = dec_units + 16'd1;
                    queue_unit({8'h00, b}, u2u_pkg::KIND_CHAR, dec_units);
                end
                else if (b[7:5] == u2u_pkg::LEAD2_TAG)
                begin
                    dec_partial = {5'b0, b[4:0], 6'b0};
                    dec_pending = 2'd1;
                end
                else if (b[7:4] == u2u_pkg::LEAD3_TAG)
                begin
                    dec_partial = {b[3:0], 12'b0};
                    dec_pending = 2'd2;
                end
                else
                begin
                    dec_halted = 1'b1;
                    queue_unit(16'h0000, u2u_pkg::KIND_BAD, dec_units);
                end
            end
            else if (dec_pending == 2'd2)
            begin
                dec_partial = dec_partial | {4'b0, b[5:0], 6'b0};
                dec_pending = 2'd1;
            end
            else
            begin
                // Last continuation byte finishes the unit
                dec_units = dec_units + 16'd1;
                queue_unit(dec_partial | {10'b0, b[5:0]}, u2u_pkg::KIND_CHAR, dec_units);
                dec_partial = '0;
                dec_pending = '0;
            end
        end
    endtask

    // Compare one result transfer with the oldest expectation
    task automatic check_result();
        unit_result_t want;
        if (expected_units.size() == 0)
        begin
            report_failure($sformatf("unexpected result unit=%h kind=%0d count=%0d",
                                     m_axis_tdata[15:0], m_axis_tuser, m_axis_tdata[31:16]));
        end
        else
        begin
            want = expected_units.pop_front();
            if (m_axis_tdata[15:0] !== want.code_unit)
                report_failure($sformatf("code_unit got %h expected %h",
                                         m_axis_tdata[15:0], want.code_unit));
            if (m_axis_tuser !== want.kind)
                report_failure($sformatf("kind got %0d expected %0d",
                                         m_axis_tuser, want.kind));
            if (m_axis_tdata[31:16] !== want.unit_count)
                report_failure($sformatf("unit_count got %0d expected %0d",
                                         m_axis_tdata[31:16], want.unit_count));
        end
    endtask

    // Watch the limit register and both streams
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_wr_en)
                dec_limit = cfg_wr_data;
            if (s_axis_tvalid && s_axis_tready)
                decode_byte(s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready)
                check_result();
        end
    end

    // Drive the result ready: random stalls, plus long hold-offs on request
    always @(posedge clk)
    begin
        if (hold_request != hold_served)
        begin
            hold_served = hold_request;
            hold_left   = hold_len;
        end
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Offer one byte, with random gaps, and hold it until the transfer
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    // Drop valid and wait until every expected result has arrived
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (expected_units.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_limit(input logic [15:0] limit);
        wait_idle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= limit;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    task automatic send_bytes(input logic [7:0] seq[]);
        foreach (seq[i])
            send_byte(seq[i]);
    endtask

    function automatic logic [7:0] cont_byte();
        // Continuation bits above the payload are not checked by the block
        if ($urandom_range(7) == 0)
            return 8'($urandom_range(1, 255));
        return 8'h80 | 8'($urandom_range(0, 63));
    endfunction

    // Extremes of each sequence length, terminators, bad leads, zero mid-sequence
    task automatic test_directed_sequences();
        send_bytes('{8'h01, 8'h7f, 8'hc0, 8'h80, 8'hdf, 8'hbf,
                     8'he0, 8'h80, 8'h80, 8'hef, 8'hff, 8'hff, 8'h00});
        // Bad continuation-class lead, ignored byte, re-arm
        send_bytes('{8'h80, 8'h41, 8'h00});
        // An all-ones lead byte is rejected too
        send_bytes('{8'hff, 8'h00});
        // Zero inside two- and three-byte sequences
        send_bytes('{8'hc3, 8'h00, 8'he2, 8'h82, 8'h00});
    endtask

    // Capacity stop at several limits, and its priority over a bad lead
    task automatic test_capacity_limit();
        write_limit(16'h0000);
        send_bytes('{8'h41, 8'h42, 8'h00});
        write_limit(16'd2);
        send_bytes('{8'h41, 8'h42, 8'h80, 8'h43, 8'h00});
        write_limit(16'd1);
        send_bytes('{8'hc3, 8'ha9, 8'he2, 8'h82, 8'hac, 8'h00});
        write_limit(16'd3);
        send_bytes('{8'h41, 8'h42, 8'h43, 8'h00});
        write_limit(16'hffff);
    endtask

    // One random string: mostly well-formed characters, some noise and truncation
    task automatic send_random_string();
        int n_chars;
        int pick;
        bit ended;
        n_chars = ($urandom_range(9) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 12);
        ended = 1'b0;
        for (int i = 0; i < n_chars && !ended; i++)
        begin
            pick = $urandom_range(99);
            if (pick < 45)
                send_byte(8'($urandom_range(1, 127)));
            else if (pick < 68)
            begin
                send_byte(8'hc0 | 8'($urandom_range(0, 31)));
                send_byte(cont_byte());
            end
            else if (pick < 88)
            begin
                send_byte(8'he0 | 8'($urandom_range(0, 15)));
                send_byte(cont_byte());
                send_byte(cont_byte());
            end
            else if (pick < 93)
            begin
                // Truncate a sequence with the terminator
                if ($urandom_range(1))
                    send_byte(8'hc0 | 8'($urandom_range(0, 31)));
                else
                begin
                    send_byte(8'he0 | 8'($urandom_range(0, 15)));
                    if ($urandom_range(1))
                        send_byte(cont_byte());
                end
                ended = 1'b1;
            end
            else
                send_byte(8'($urandom_range(1, 255)));
        end
        send_byte(8'h00);
    endtask

    task automatic test_random_text(input int target, input int snd_pct, input int rcv_pct);
        int start;
        int pick;
        send_idle_pct = snd_pct;
        recv_idle_pct = rcv_pct;
        start = decoded_items;
        while (decoded_items - start < target)
        begin
            // Change the limit now and then, between strings
            if ($urandom_range(5) == 0)
            begin
                pick = $urandom_range(3);
                if (pick == 0)
                    write_limit(16'h0000);
                else if (pick == 1)
                    write_limit(16'hffff);
                else if (pick == 2)
                    write_limit(16'($urandom_range(1, 16)));
                else
                    write_limit(16'($urandom_range(0, 65535)));
            end
            send_random_string();
        end
    endtask

    // Hold off the result side long enough for the input to stall
    task automatic test_output_stall();
        write_limit(16'hffff);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_len      = 300;
        hold_request  = hold_request + 1;
        for (int i = 0; i < 60; i++)
            send_byte(8'($urandom_range(1, 127)));
        send_byte(8'h00);
    endtask

    initial
    begin
        send_idle_pct = 22;
        recv_idle_pct = 68;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_sequences();
        test_capacity_limit();
        test_random_text(230, 22, 68);
        test_random_text(230, 68, 22);
        test_output_stall();
        test_random_text(230, 0, 0);

        wait_idle();
        if (error_count == 0 && expected_units.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/u2u_pkg.sv
hdl/u2u_core.sv
hdl/utf8_to_ucs2_stream_decoder.sv
tb/sv/tb.sv
